// ----- rtl/masked_max_and_std_dev_macros.svh -----
// Assertion macros shared by the masked max and standard deviation block.
`ifndef MASKED_MAX_AND_STD_DEV_MACROS_SVH
`define MASKED_MAX_AND_STD_DEV_MACROS_SVH
`ifndef SYNTHESIS
`define MMSD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MMSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MMSD_ASSERT_IMPL(label, ante, cons)
`define MMSD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/mmsd_pkg.sv -----
// Shared constants and types of the masked max and standard deviation block.
`timescale 1ns / 1ps
package mmsd_pkg;
	localparam int SAMPLE_BITS = 20;
	localparam int MAX_PIXELS  = 1048576;
	localparam int CNT_W       = 21;
	localparam int MAX_W       = 21;
	localparam int SUM_W       = 40;
	localparam int SSQ_W       = 60;
	localparam int SQ_W        = 2 * SAMPLE_BITS;
	localparam int SD_W        = 20;
	localparam int PROD_W      = 81;
	localparam int VAR_W       = 40;
	localparam int REM_W       = CNT_W + 1;

	// one closed frame, handed from the accumulator to the finisher
	typedef struct packed {
		logic signed [MAX_W-1:0] max_v;
		logic                    none;
		logic signed [SUM_W-1:0] sum;
		logic [SSQ_W-1:0]        ssq;
		logic [CNT_W-1:0]        cnt;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage

// ----- rtl/mmsd_front.sv -----
// Pixel front end: square, max tracking and per-frame accumulation.
`timescale 1ns / 1ps
module mmsd_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   abs_mode,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [mmsd_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                   masked,
	input  logic                                   frame_end,
	input  mmsd_pkg::q_stat_t                      q_stat,
	output logic                                   push,
	output mmsd_pkg::frame_t                       frame
);
	import mmsd_pkg::*;

	logic [SAMPLE_BITS-1:0]   mag_c;
	logic signed [MAX_W-1:0]  val_c;
	logic [SQ_W-1:0]          sq_c;

	logic                     vld_s1;
	logic signed [MAX_W-1:0]  val_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic [SQ_W-1:0]          sq_s1;
	logic                     masked_s1;
	logic                     end_s1;

	logic signed [MAX_W-1:0]  max_q;
	logic                     seen_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SSQ_W-1:0]         ssq_q;
	logic [CNT_W-1:0]         cnt_q;

	logic [CNT_W-1:0]         cnt_n;
	logic signed [SUM_W-1:0]  sum_n;
	logic [SSQ_W-1:0]         ssq_n;
	logic signed [MAX_W-1:0]  max_n;
	logic                     seen_n;
	logic                     close;
	logic                     adv;

	always_comb begin
		mag_c = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
		val_c = abs_mode ? MAX_W'({1'b0, mag_c}) : MAX_W'(sample);
		sq_c  = mag_c * mag_c;
	end

	always_comb begin
		cnt_n  = cnt_q + 1'b1;
		sum_n  = sum_q + SUM_W'(smp_s1);
		ssq_n  = ssq_q + SSQ_W'(sq_s1);
		max_n  = max_q;
		if (!masked_s1 && (!seen_q || (val_s1 > max_q)))
			max_n = val_s1;
		seen_n = seen_q | ~masked_s1;
		close  = end_s1 || (cnt_n == CNT_W'(MAX_PIXELS));
		adv    = !(vld_s1 && close && q_stat.full);
		push   = vld_s1 && close && adv;
		in_stall = !adv;
		frame.max_v = seen_n ? max_n : '0;
		frame.none  = !seen_n;
		frame.sum   = sum_n;
		frame.ssq   = ssq_n;
		frame.cnt   = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			val_s1    <= val_c;
			smp_s1    <= sample;
			sq_s1     <= sq_c;
			masked_s1 <= masked;
			end_s1    <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= '0;
			seen_q <= 1'b0;
			sum_q  <= '0;
			ssq_q  <= '0;
			cnt_q  <= '0;
		end else if (adv && vld_s1) begin
			if (close) begin
				max_q  <= '0;
				seen_q <= 1'b0;
				sum_q  <= '0;
				ssq_q  <= '0;
				cnt_q  <= '0;
			end else begin
				max_q  <= max_n;
				seen_q <= seen_n;
				sum_q  <= sum_n;
				ssq_q  <= ssq_n;
				cnt_q  <= cnt_n;
			end
		end
	end
endmodule

// ----- rtl/mmsd_queue.sv -----
// Two-entry frame queue between the accumulator and the finisher.
`timescale 1ns / 1ps
`include "masked_max_and_std_dev_macros.svh"
module mmsd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mmsd_pkg::frame_t   wr_frame,
	input  logic               pop,
	output mmsd_pkg::frame_t   rd_frame,
	output mmsd_pkg::q_stat_t  q_stat
);
	import mmsd_pkg::*;

	frame_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_comb begin
		q_stat.full  = (cnt_q == 2'd2);
		q_stat.empty = (cnt_q == 2'd0);
		rd_frame     = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`MMSD_ASSERT_IMPL(q_no_overflow, push, cnt_q != 2'd2)
	`MMSD_ASSERT_IMPL(q_no_underflow, pop, cnt_q != 2'd0)
endmodule

// ----- rtl/mmsd_back.sv -----
// Frame finisher: shift-add products, two restoring divides, integer square root.
`timescale 1ns / 1ps
`include "masked_max_and_std_dev_macros.svh"
module mmsd_back (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  mmsd_pkg::q_stat_t                        q_stat,
	input  mmsd_pkg::frame_t                         rd_frame,
	output logic                                     pop,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [mmsd_pkg::MAX_W-1:0]        max_value,
	output logic                                     max_none,
	output logic [mmsd_pkg::SD_W-1:0]                std_dev,
	output logic [mmsd_pkg::CNT_W-1:0]               pixel_count
);
	import mmsd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MULN = 3'd1;
	localparam logic [2:0] ST_MULS = 3'd2;
	localparam logic [2:0] ST_DIV1 = 3'd3;
	localparam logic [2:0] ST_DIV2 = 3'd4;
	localparam logic [2:0] ST_SQRT = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]               state_q;
	logic [6:0]               cnt_q;
	logic [PROD_W-1:0]        acc_q;
	logic [PROD_W-1:0]        mcand_q;
	logic [SUM_W-1:0]         mplr_q;
	logic [SUM_W-1:0]         sabs_q;
	logic [CNT_W-1:0]         n_q;
	logic [REM_W-1:0]         rem_q;
	logic [PROD_W-1:0]        quo_q;
	logic [VAR_W-1:0]         x_q;
	logic [VAR_W-1:0]         res_q;
	logic [VAR_W-1:0]         bit_q;
	logic signed [MAX_W-1:0]  max_q;
	logic                     none_q;

	logic [PROD_W:0]          sub_c;
	logic [PROD_W-1:0]        acc_nx;
	logic [REM_W-1:0]         r_sh;
	logic                     ge;
	logic [REM_W-1:0]         r_nx;
	logic [PROD_W-1:0]        quo_nx;
	logic [VAR_W-1:0]         sq_t;
	logic                     load_out;

	always_comb begin
		sub_c  = {1'b0, acc_q} - {1'b0, mcand_q};
		acc_nx = acc_q;
		if (mplr_q[0])
			acc_nx = (state_q == ST_MULS) ? sub_c[PROD_W-1:0] : (acc_q + mcand_q);
		r_sh   = {rem_q[REM_W-2:0], quo_q[PROD_W-1]};
		ge     = (r_sh >= {1'b0, n_q});
		r_nx   = ge ? (r_sh - {1'b0, n_q}) : r_sh;
		quo_nx = {quo_q[PROD_W-2:0], ge};
		sq_t   = res_q + bit_q;
		pop    = (state_q == ST_IDLE) && !q_stat.empty;
		load_out = (state_q == ST_DONE) && (!out_valid || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_MULN;
						cnt_q   <= 7'(CNT_W - 1);
					end
				end
				ST_MULN: begin
					if (cnt_q == '0) begin
						state_q <= ST_MULS;
						cnt_q   <= 7'(SUM_W - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_MULS: begin
					if (cnt_q == '0) begin
						state_q <= ST_DIV1;
						cnt_q   <= 7'(PROD_W - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DIV1: begin
					if (cnt_q == '0) begin
						state_q <= ST_DIV2;
						cnt_q   <= 7'(PROD_W - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DIV2: begin
					if (cnt_q == '0) begin
						state_q <= ST_SQRT;
						cnt_q   <= 7'(VAR_W / 2 - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0)
						state_q <= ST_DONE;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_DONE: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q     <= rd_frame.cnt;
				max_q   <= rd_frame.max_v;
				none_q  <= rd_frame.none;
				acc_q   <= '0;
				mcand_q <= PROD_W'(rd_frame.ssq);
				mplr_q  <= SUM_W'(rd_frame.cnt);
				sabs_q  <= rd_frame.sum[SUM_W-1] ? (~rd_frame.sum + 1'b1) : rd_frame.sum;
			end
			ST_MULN: begin
				if (cnt_q == '0) begin
					mcand_q <= PROD_W'(sabs_q);
					mplr_q  <= sabs_q;
				end else begin
					mcand_q <= {mcand_q[PROD_W-2:0], 1'b0};
					mplr_q  <= {1'b0, mplr_q[SUM_W-1:1]};
				end
				acc_q <= acc_nx;
			end
			ST_MULS: begin
				mcand_q <= {mcand_q[PROD_W-2:0], 1'b0};
				mplr_q  <= {1'b0, mplr_q[SUM_W-1:1]};
				acc_q   <= acc_nx;
				if (cnt_q == '0) begin
					quo_q <= acc_nx;
					rem_q <= '0;
				end
			end
			ST_DIV1: begin
				quo_q <= quo_nx;
				rem_q <= (cnt_q == '0) ? '0 : r_nx;
			end
			ST_DIV2: begin
				quo_q <= quo_nx;
				rem_q <= r_nx;
				if (cnt_q == '0) begin
					x_q   <= quo_nx[VAR_W-1:0];
					res_q <= '0;
					bit_q <= VAR_W'(1) << (VAR_W - 2);
				end
			end
			ST_SQRT: begin
				if (x_q >= sq_t) begin
					x_q   <= x_q - sq_t;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			max_value   <= max_q;
			max_none    <= none_q;
			std_dev     <= (res_q[VAR_W-1:SD_W] != '0) ? '1 : res_q[SD_W-1:0];
			pixel_count <= n_q;
		end
	end

	`MMSD_ASSERT_IMPL(diff_nonneg, (state_q == ST_MULS) && mplr_q[0], !sub_c[PROD_W])
	`MMSD_ASSERT_IMPL(var_fits, (state_q == ST_DIV2) && (cnt_q == '0), quo_nx[PROD_W-1:VAR_W] == '0)
	`MMSD_ASSERT_IMPL(div_nonzero, (state_q == ST_DIV1) || (state_q == ST_DIV2), n_q != '0)
	`MMSD_ASSERT_NEXT(done_loads, load_out, out_valid && (state_q == ST_IDLE))
endmodule

// ----- rtl/masked_max_and_std_dev.sv -----
// Top level of the masked max and standard deviation block.
`timescale 1ns / 1ps
// Per-frame statistics over a stream of signed Q8.12 pixels.
// Input channel (in_valid / in_stall): one pixel word per cycle with sample,
// masked and frame_end. A word is taken when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall): one word per frame with max_value,
// max_none, std_dev and pixel_count, held steady while out_stall is high.
// Config channel (cfg_valid / cfg_ready): abs_mode, always ready; write it
// only between frames.
// Throughput: one pixel per cycle inside a frame while in_stall is low. Each
// closed frame goes through the finisher's 21-step and 40-step shift-add
// products, two 81-step restoring divides and a 20-step square root; a
// two-entry frame queue covers short frames, beyond that in_stall rises on a
// frame's last pixel until a queue entry frees.
// A frame also closes on its 1048576th pixel.
// Reset clears the accumulators, the queue, abs_mode and out_valid.
// While out_stall is high the finished word waits in the output register; the
// front keeps accumulating pixels until a frame closes with the queue full.
module masked_max_and_std_dev (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic                                      abs_mode,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic signed [mmsd_pkg::SAMPLE_BITS-1:0]   sample,
	input  logic                                      masked,
	input  logic                                      frame_end,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [mmsd_pkg::MAX_W-1:0]         max_value,
	output logic                                      max_none,
	output logic [mmsd_pkg::SD_W-1:0]                 std_dev,
	output logic [mmsd_pkg::CNT_W-1:0]                pixel_count
);
	import mmsd_pkg::*;

	logic    abs_mode_q;
	logic    push;
	logic    pop;
	frame_t  wr_frame;
	frame_t  rd_frame;
	q_stat_t q_stat;

	// hold the mode register; the port never refuses a write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			abs_mode_q <= abs_mode;
		end
	end

	// accumulate pixels, push each closed frame
	mmsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.abs_mode  (abs_mode_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.masked    (masked),
		.frame_end (frame_end),
		.q_stat    (q_stat),
		.push      (push),
		.frame     (wr_frame)
	);

	// decouple the pixel rate from the finisher
	mmsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_frame (wr_frame),
		.pop      (pop),
		.rd_frame (rd_frame),
		.q_stat   (q_stat)
	);

	// turn sums into the standard deviation and drive the result word
	mmsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.rd_frame    (rd_frame),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.max_value   (max_value),
		.max_none    (max_none),
		.std_dev     (std_dev),
		.pixel_count (pixel_count)
	);
endmodule
